>>> design/tsf_pkg.sv
// shared types and constants for the treble shelf filter
package tsf_pkg;

  localparam int MAX_CHANNELS = 8;
  localparam int CH_W         = 3;
  localparam int SAMPLE_W     = 16;
  localparam int GAIN_W       = 16;
  localparam int MEM_W        = 24;
  localparam int CFG_IDX_W    = 2;
  localparam int CFG_DATA_W   = 16;

  localparam logic [16:0]       ALPHA_Q15  = 17'd4915;
  localparam logic [GAIN_W-1:0] UNITY_Q14  = 16'd16384;
  localparam logic [GAIN_W-1:0] RAMP_RESET = 16'd16;

  localparam logic [CFG_IDX_W-1:0] REG_GAIN_TARGET = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RAMP_STEP   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_NEAR_UNITY  = 2'd2;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample_in;
    logic [CH_W-1:0]            channel;
  } item_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample_out;
    logic                       ramping;
  } result_t;

  typedef struct packed {
    logic load;      // capture request, read channel memory
    logic mul_en;    // register a product
    logic mul_high;  // 0: diff * alpha, 1: high * gain
    logic do_low;    // update lowpass memory and gain
    logic do_out;    // load the output register
  } cmd_t;

  typedef struct packed {
    logic bypass;    // request passes through untouched
  } status_t;

endpackage

>>> design/tsf_dp.sv
// datapath: config registers, channel memory, shared multiplier, output register
module tsf_dp (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [tsf_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [tsf_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  tsf_pkg::item_t                  item,
  input  tsf_pkg::cmd_t                   cmd,
  output tsf_pkg::status_t                status,
  output tsf_pkg::result_t                result
);

  logic [tsf_pkg::GAIN_W-1:0] gain_target;
  logic [tsf_pkg::GAIN_W-1:0] ramp_step;
  logic                       near_unity;
  logic [tsf_pkg::GAIN_W-1:0] gain_now;
  logic [tsf_pkg::GAIN_W-1:0] gain_next;

  logic signed [tsf_pkg::MEM_W-1:0] mem [tsf_pkg::MAX_CHANNELS];

  logic signed [tsf_pkg::SAMPLE_W-1:0] x_r;
  logic [tsf_pkg::CH_W-1:0]            ch_r;
  logic signed [tsf_pkg::MEM_W-1:0]    mem_cur;
  logic                                byp_r;
  logic signed [tsf_pkg::MEM_W-1:0]    low_r;
  logic signed [24:0]                  high_r;
  logic signed [41:0]                  prod_r;

  logic signed [24:0] xq;
  logic signed [24:0] diff;
  logic signed [24:0] mul_a;
  logic signed [16:0] mul_b;
  logic signed [41:0] prod;
  logic signed [41:0] rnd;
  logic signed [41:0] shifted;
  logic signed [26:0] low_full;
  logic signed [tsf_pkg::MEM_W-1:0] low_sat;
  logic signed [24:0] high;
  logic signed [42:0] total;
  logic signed [42:0] total_rnd;
  logic signed [42:0] quot;
  logic signed [tsf_pkg::SAMPLE_W-1:0] y_sat;
  logic [16:0] gain_up;
  logic [tsf_pkg::GAIN_W-1:0] gain_gap;

  // passthrough when channel is out of range or gain settled on target with near_unity set
  always_comb begin
    status.bypass = ({1'b0, item.channel} >= (tsf_pkg::CH_W + 1)'(tsf_pkg::MAX_CHANNELS)) ||
                    ((gain_now == gain_target) && near_unity);
  end

  // shared multiplier
  always_comb begin
    xq    = {x_r[15], x_r, 8'b0};
    diff  = xq - {mem_cur[23], mem_cur};
    mul_a = cmd.mul_high ? high_r : diff;
    mul_b = cmd.mul_high ? $signed({1'b0, gain_now}) : $signed(tsf_pkg::ALPHA_Q15);
    prod  = mul_a * mul_b;
  end

  // lowpass update, round half up then saturate to memory width
  always_comb begin
    rnd      = prod_r + 42'sd16384;
    shifted  = rnd >>> 15;
    low_full = shifted[26:0] + {{3{mem_cur[23]}}, mem_cur};
    if (low_full > 27'sd8388607) begin
      low_sat = 24'sh7FFFFF;
    end else if (low_full < -27'sd8388608) begin
      low_sat = 24'sh800000;
    end else begin
      low_sat = low_full[23:0];
    end
    high = xq - {low_sat[23], low_sat};
  end

  // gain steps toward target, stopping on it
  always_comb begin
    gain_up   = {1'b0, gain_now} + {1'b0, ramp_step};
    gain_gap  = gain_now - gain_target;
    gain_next = gain_now;
    if (gain_now < gain_target) begin
      gain_next = (gain_up > {1'b0, gain_target}) ? gain_target : gain_up[15:0];
    end else if (gain_now > gain_target) begin
      gain_next = (gain_gap <= ramp_step) ? gain_target : gain_now - ramp_step;
    end
  end

  // output: low * unity + high * gain, truncate toward zero, saturate
  always_comb begin
    total     = (43'(low_r) <<< 14) + 43'(prod_r);
    total_rnd = total[42] ? total + 43'sd4194303 : total;
    quot      = total_rnd >>> 22;
    if (quot > 43'sd32767) begin
      y_sat = 16'sh7FFF;
    end else if (quot < -43'sd32768) begin
      y_sat = 16'sh8000;
    end else begin
      y_sat = quot[15:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      gain_target <= tsf_pkg::UNITY_Q14;
      ramp_step   <= tsf_pkg::RAMP_RESET;
      near_unity  <= 1'b1;
      gain_now    <= tsf_pkg::UNITY_Q14;
      for (int i = 0; i < tsf_pkg::MAX_CHANNELS; i++) begin
        mem[i] <= '0;
      end
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          tsf_pkg::REG_GAIN_TARGET: gain_target <= cfg_data;
          tsf_pkg::REG_RAMP_STEP:   ramp_step   <= cfg_data;
          tsf_pkg::REG_NEAR_UNITY:  near_unity  <= cfg_data[0];
          default: ;
        endcase
      end
      if (cmd.do_low) begin
        mem[ch_r] <= low_sat;
        gain_now  <= gain_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      x_r     <= item.sample_in;
      ch_r    <= item.channel;
      mem_cur <= mem[item.channel];
      byp_r   <= status.bypass;
    end
    if (cmd.mul_en) begin
      prod_r <= prod;
    end
    if (cmd.do_low) begin
      low_r  <= low_sat;
      high_r <= high;
    end
    if (cmd.do_out) begin
      result.sample_out <= byp_r ? x_r : y_sat;
      result.ramping    <= (gain_now != gain_target);
    end
  end

endmodule

>>> design/tsf_ctrl.sv
// controller: sequences one request through the shared multiplier
module tsf_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              item_valid,
  output logic              item_ready,
  output logic              result_valid,
  input  logic              result_ready,
  input  tsf_pkg::status_t  status,
  output tsf_pkg::cmd_t     cmd
);

  typedef enum logic [2:0] {
    IDLE,
    MUL_ALPHA,
    LOW,
    MUL_GAIN,
    DONE
  } state_t;

  state_t state;
  logic   out_free;
  logic   accept;

  assign out_free   = !result_valid || result_ready;
  assign item_ready = (state == IDLE);
  assign accept     = item_valid && item_ready;

  always_comb begin
    cmd          = '0;
    cmd.load     = accept;
    cmd.mul_en   = (state == MUL_ALPHA) || (state == MUL_GAIN);
    cmd.mul_high = (state == MUL_GAIN);
    cmd.do_low   = (state == LOW);
    cmd.do_out   = (state == DONE) && out_free;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= IDLE;
      result_valid <= 1'b0;
    end else begin
      if (cmd.do_out) begin
        result_valid <= 1'b1;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
      case (state)
        IDLE: begin
          if (accept) begin
            state <= status.bypass ? DONE : MUL_ALPHA;
          end
        end
        MUL_ALPHA: state <= LOW;
        LOW:       state <= MUL_GAIN;
        MUL_GAIN:  state <= DONE;
        DONE: begin
          if (out_free) begin
            state <= IDLE;
          end
        end
        default:   state <= IDLE;
      endcase
    end
  end

endmodule

>>> design/treble_shelf_filter.sv
// top level of the treble shelf filter
// First-order high-shelf filter for interleaved audio: each request carries a
// signed 16-bit sample and its channel; the block keeps a one-pole lowpass
// state per channel and one shared gain that ramps toward gain_target by
// ramp_step per filtered sample. A filtered request runs accept, alpha
// multiply, lowpass and gain update, gain multiply, output load in order, so
// the single 25x17 multiplier serves both products; a passthrough request
// goes from accept straight to output load. The next request is accepted the
// cycle after the result enters the output register, even while that result
// waits to be taken. The user must write registers via cfg_we, cfg_index,
// cfg_data only while idle, which is not enforced; index 3 is ignored.
module treble_shelf_filter (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [tsf_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [tsf_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic                            item_valid,
  output logic                            item_ready,
  input  tsf_pkg::item_t                  item,
  output logic                            result_valid,
  input  logic                            result_ready,
  output tsf_pkg::result_t                result
);

  tsf_pkg::cmd_t    cmd;
  tsf_pkg::status_t status;

  tsf_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .status       (status),
    .cmd          (cmd)
  );

  tsf_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .item      (item),
    .cmd       (cmd),
    .status    (status),
    .result    (result)
  );

endmodule

>>> design/tsf_check.sv
// port-level checks for the treble shelf filter, bound to the top level
module tsf_check (
  input logic             clk,
  input logic             rst,
  input logic             item_valid,
  input logic             item_ready,
  input logic             result_valid,
  input logic             result_ready,
  input tsf_pkg::result_t result
);

  // a held result keeps its value
  assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> result_valid && $stable(result))
    else $error("result changed while stalled");

  // one request in work at a time
  assert property (@(posedge clk) disable iff (rst)
    item_valid && item_ready |=> !item_ready)
    else $error("request accepted while busy");

  // reset leaves the block empty and ready
  assert property (@(posedge clk)
    rst |=> !result_valid && item_ready)
    else $error("block not empty after reset");

  // a new result appears only after a request was taken
  assert property (@(posedge clk) disable iff (rst)
    $rose(result_valid) |-> !item_ready || $past(!item_ready))
    else $error("result without a request");

endmodule

bind treble_shelf_filter tsf_check u_tsf_check (
  .clk          (clk),
  .rst          (rst),
  .item_valid   (item_valid),
  .item_ready   (item_ready),
  .result_valid (result_valid),
  .result_ready (result_ready),
  .result       (result)
);
